>>> rtl/core/mea_pkg.sv
// Package for the altitude median / moving-average alarm block.
// Holds shared constants, codes, controller states and the command/status structs.
// No dependencies.
package mea_pkg;

    localparam int WINDOW_LEN_DEF   = 5;
    localparam int SAMPLE_WIDTH_DEF = 22;

    localparam int              ALPHA_W     = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd655;

    localparam int TIME_W       = 32;
    localparam int BLINK_PERIOD = 1200;
    localparam int BLINK_ON     = 600;
    // The blink period is 16 * 75: the low nibble of the time stamp passes straight
    // into the remainder and the upper bits are reduced modulo 75 by a reciprocal
    // multiply, exact for every 28-bit operand.
    localparam int BLINK_SHIFT  = 4;
    localparam int BLINK_DIV    = 75;
    localparam int BLINK_DIV_W  = 7;
    localparam int REM_W        = BLINK_DIV_W + BLINK_SHIFT;
    localparam int RECIP_W      = 29;
    localparam int RECIP_SHIFT  = 35;
    localparam logic [RECIP_W-1:0] BLINK_RECIP = 29'd458129845;
    localparam int MOD_STEPS    = 2;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHA       = 3'd0,
        REG_DANGER_HIGH = 3'd1,
        REG_DANGER_LOW  = 3'd2,
        REG_WARN_HIGH   = 3'd3,
        REG_WARN_LOW    = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LVL_CLEAR  = 2'd0,
        LVL_WARN   = 2'd1,
        LVL_DANGER = 2'd2
    } alarm_level_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_CLEAR  = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACCUM,
        ST_BAND,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic diff;
        logic mul_lo;
        logic mul_hi;
        logic accum;
        logic clear_acc;
        logic band;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/core/mea_ctrl.sv
// Controller state machine for the altitude alarm block.
// Sequences the datapath through scan, multiply, accumulate and banding steps.
// Depends on mea_pkg.
module mea_ctrl
    import mea_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    req_t   kind_reg;
    req_t   kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= REQ_SAMPLE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    kind_next  = req_t'(req_type);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    // A clear word clears the average and keeps the alarm state.
                    state_next = (kind_reg == REQ_CLEAR) ? ST_ACCUM : ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum     = 1'b1;
                cmd.clear_acc = (kind_reg == REQ_CLEAR);
                state_next    = (kind_reg == REQ_CLEAR) ? ST_FIN : ST_BAND;
            end
            ST_BAND:
            begin
                cmd.band   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/mea_dp.sv
// Datapath for the altitude alarm block: window, rank search, remainder unit,
// average accumulator, banding, configuration registers and output register.
// Depends on mea_pkg.
module mea_dp
    import mea_pkg::*;
#(
    parameter int WINDOW_LEN   = WINDOW_LEN_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int CFG_DATA_W   = (SAMPLE_WIDTH > ALPHA_W) ? SAMPLE_WIDTH : ALPHA_W
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  dp_cmd_t                        cmd,
    output dp_status_t                     status,
    input  logic                           req_type,
    input  logic signed [SAMPLE_WIDTH-1:0] altitude_in,
    input  logic [TIME_W-1:0]              time_ms,
    input  logic                           cfg_valid,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] median_out,
    output logic signed [SAMPLE_WIDTH-1:0] smoothed_out,
    output logic [1:0]                     alarm_level,
    output logic                           alarm_on
);

    localparam int IDX_W       = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int NUM_W       = $clog2(WINDOW_LEN + 1);
    localparam int RANK        = WINDOW_LEN / 2;
    localparam int SCAN_CYCLES = (WINDOW_LEN > MOD_STEPS) ? WINDOW_LEN : MOD_STEPS;
    localparam int SCAN_W      = $clog2(SCAN_CYCLES);
    localparam int ACC_W       = SAMPLE_WIDTH + ALPHA_W;
    localparam int DIFF_W      = ACC_W + 1;
    localparam int HI_W        = SAMPLE_WIDTH + 1;
    localparam int PHI_W       = HI_W + ALPHA_W + 1;
    localparam int HIGH_W      = TIME_W - BLINK_SHIFT;
    localparam int PROD_W      = HIGH_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // Configuration registers.
    logic [ALPHA_W-1:0]             alpha_reg;
    logic signed [SAMPLE_WIDTH-1:0] danger_high_reg;
    logic signed [SAMPLE_WIDTH-1:0] danger_low_reg;
    logic signed [SAMPLE_WIDTH-1:0] warn_high_reg;
    logic signed [SAMPLE_WIDTH-1:0] warn_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg       <= ALPHA_RESET;
            danger_high_reg <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            danger_low_reg  <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            warn_high_reg   <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            warn_low_reg    <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ALPHA:       alpha_reg       <= cfg_data[ALPHA_W-1:0];
                REG_DANGER_HIGH: danger_high_reg <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_DANGER_LOW:  danger_low_reg  <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_WARN_HIGH:   warn_high_reg   <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_WARN_LOW:    warn_low_reg    <= cfg_data[SAMPLE_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    // Sample window and its write pointer.
    logic signed [SAMPLE_WIDTH-1:0] window_reg [WINDOW_LEN];
    logic [IDX_W-1:0]               write_slot_reg;
    logic [IDX_W-1:0]               slot_eff;
    logic [IDX_W-1:0]               slot_next;

    always_comb
    begin
        if ({1'b0, write_slot_reg} >= (IDX_W+1)'(WINDOW_LEN))
        begin
            slot_eff = '0;
        end
        else
        begin
            slot_eff = write_slot_reg;
        end
        if (slot_eff == IDX_W'(WINDOW_LEN - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_eff + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WINDOW_LEN; j++)
            begin
                window_reg[j] <= '0;
            end
            write_slot_reg <= '0;
        end
        else if (cmd.load && (req_t'(req_type) == REQ_SAMPLE))
        begin
            window_reg[slot_eff] <= altitude_in;
            write_slot_reg       <= slot_next;
        end
    end

    // Rank search: one candidate per cycle is compared against the whole window.
    logic [SCAN_W-1:0]              scan_cnt_reg;
    logic [IDX_W-1:0]               cand_idx;
    logic                           cand_valid;
    logic signed [SAMPLE_WIDTH-1:0] cand;
    logic [NUM_W-1:0]               lt_cnt;
    logic [NUM_W-1:0]               eq_cnt;
    logic                           rank_hit;

    assign cand_idx   = scan_cnt_reg[IDX_W-1:0];
    assign cand_valid = ({1'b0, scan_cnt_reg} < (SCAN_W+1)'(WINDOW_LEN));

    always_comb
    begin
        cand   = '0;
        lt_cnt = '0;
        eq_cnt = '0;
        for (int j = 0; j < WINDOW_LEN; j++)
        begin
            if (cand_idx == IDX_W'(j))
            begin
                cand = window_reg[j];
            end
        end
        for (int j = 0; j < WINDOW_LEN; j++)
        begin
            lt_cnt = lt_cnt + NUM_W'(window_reg[j] < cand);
            eq_cnt = eq_cnt + NUM_W'(window_reg[j] == cand);
        end
        rank_hit = (lt_cnt <= NUM_W'(RANK)) && (NUM_W'(RANK) < (lt_cnt + eq_cnt));
    end

    assign status.scan_last = (scan_cnt_reg == SCAN_W'(SCAN_CYCLES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            scan_cnt_reg <= '0;
        end
        else if (cmd.scan_step && !status.scan_last)
        begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
    end

    // Remainder of the time stamp by the blink period, worked out at the start of
    // the scan: the quotient of the upper bits by 75 comes from a reciprocal
    // multiply, then a subtract leaves the upper remainder.
    logic [TIME_W-1:0] time_reg;
    logic [HIGH_W-1:0] time_hi;
    logic [PROD_W-1:0] recip_prod;
    logic [QUOT_W-1:0] quot_reg;
    logic [HIGH_W-1:0] quot_back;
    logic [HIGH_W-1:0] high_rem;
    logic [REM_W-1:0]  rem_reg;
    logic              mod_mul;
    logic              mod_sub;

    assign time_hi    = time_reg[TIME_W-1:BLINK_SHIFT];
    assign recip_prod = PROD_W'(time_hi) * PROD_W'(BLINK_RECIP);
    assign quot_back  = HIGH_W'(quot_reg) * HIGH_W'(BLINK_DIV);
    assign high_rem   = time_hi - quot_back;
    assign mod_mul    = cmd.scan_step && (scan_cnt_reg == SCAN_W'(0));
    assign mod_sub    = cmd.scan_step && (scan_cnt_reg == SCAN_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            time_reg <= time_ms;
        end
        if (mod_mul)
        begin
            quot_reg <= recip_prod[PROD_W-1:RECIP_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (cmd.load)
        begin
            rem_reg <= '0;
        end
        else if (mod_sub)
        begin
            rem_reg <= {high_rem[BLINK_DIV_W-1:0], time_reg[BLINK_SHIFT-1:0]};
        end
    end

    // Median, difference and the two partial products of the average update.
    logic signed [SAMPLE_WIDTH-1:0] median_reg;
    logic signed [DIFF_W-1:0]       diff_reg;
    logic [2*ALPHA_W-1:0]           plo_reg;
    logic signed [PHI_W-1:0]        phi_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]               median_q;
    logic signed [PHI_W-1:0]        acc_sum;

    assign median_q = {median_reg, {ALPHA_W{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && cand_valid && rank_hit)
        begin
            median_reg <= cand;
        end
        if (cmd.diff)
        begin
            diff_reg <= $signed({median_q[ACC_W-1], median_q})
                      - $signed({acc_reg[ACC_W-1], acc_reg});
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= diff_reg[ALPHA_W-1:0] * alpha_reg;
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= $signed(diff_reg[DIFF_W-1:ALPHA_W]) * $signed({1'b0, alpha_reg});
        end
    end

    // The low partial product only contributes its floor above the binary point.
    assign acc_sum = $signed({{(PHI_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg})
                   + phi_reg
                   + $signed(PHI_W'(plo_reg[2*ALPHA_W-1:ALPHA_W]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.accum)
        begin
            if (cmd.clear_acc)
            begin
                acc_reg <= '0;
            end
            else
            begin
                acc_reg <= acc_sum[ACC_W-1:0];
            end
        end
    end

    // Band classification on the full-precision average.
    alarm_level_t alarm_level_reg;
    logic         alarm_pin_reg;
    logic         is_danger;
    logic         is_warn;
    logic         blink_on;

    always_comb
    begin
        is_danger = (acc_reg >= $signed({danger_high_reg, {ALPHA_W{1'b0}}}))
                 || (acc_reg <= $signed({danger_low_reg, {ALPHA_W{1'b0}}}));
        is_warn   = (acc_reg >= $signed({warn_high_reg, {ALPHA_W{1'b0}}}))
                 || (acc_reg <= $signed({warn_low_reg, {ALPHA_W{1'b0}}}));
        blink_on  = (rem_reg < REM_W'(BLINK_ON));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_level_reg <= LVL_CLEAR;
            alarm_pin_reg   <= 1'b0;
        end
        else if (cmd.band)
        begin
            if (is_danger)
            begin
                alarm_level_reg <= LVL_DANGER;
                alarm_pin_reg   <= 1'b1;
            end
            else if (is_warn)
            begin
                alarm_level_reg <= LVL_WARN;
                alarm_pin_reg   <= blink_on;
            end
            else
            begin
                alarm_level_reg <= LVL_CLEAR;
                alarm_pin_reg   <= 1'b0;
            end
        end
    end

    // Output register: the next word can be worked on while this one waits.
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] median_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] smoothed_out_reg;
    logic [1:0]                     alarm_level_out_reg;
    logic                           alarm_on_reg;

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            median_out_reg      <= median_reg;
            smoothed_out_reg    <= acc_reg[ACC_W-1:ALPHA_W];
            alarm_level_out_reg <= alarm_level_reg;
            alarm_on_reg        <= alarm_pin_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_out   = median_out_reg;
    assign smoothed_out = smoothed_out_reg;
    assign alarm_level  = alarm_level_out_reg;
    assign alarm_on     = alarm_on_reg;

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, write_slot_reg} < (IDX_W+1)'(WINDOW_LEN)))
        else $error("write slot beyond window");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg < REM_W'(BLINK_PERIOD)))
        else $error("blink remainder out of range");

    a_clear_pin_off: assert property (@(posedge clk) disable iff (!rst_n)
        (alarm_level_reg == LVL_CLEAR) |-> !alarm_pin_reg)
        else $error("alarm pin on in clear band");

    a_danger_pin_on: assert property (@(posedge clk) disable iff (!rst_n)
        (alarm_level_reg == LVL_DANGER) |-> alarm_pin_reg)
        else $error("alarm pin off in danger band");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before it was taken");

endmodule

>>> rtl/core/median_ema_altitude_alarm_unit.sv
// Altitude alarm block: running median over a sample window, exponential
// average of the median, and a three-band alarm with a blinking warning.
//
// Channels: an input word (req_type, altitude_in, time_ms) on in_valid/in_ready,
// a result word (median_out, smoothed_out, alarm_level, alarm_on) on
// out_valid/out_ready, and a configuration write channel cfg_valid/cfg_ready
// with cfg_index and cfg_data. cfg_ready is always high; write only while idle.
// One result word comes back for every input word.
// Sequence: a word goes through rank search (one window entry per cycle; the
// blink phase of the time stamp is found alongside by a reciprocal multiply
// and a subtract). A sample word then takes difference, low and high
// multiply, accumulate, banding and output load; a clear word goes from the
// search through an accumulate step that clears the average to the output
// load. The block takes a new word in the cycle after the result is loaded.
// Reset: window, average and alarm state clear to zero, registers to defaults.
// When the receiver stalls, the result waits in the output register; the next
// word is still accepted and worked on, and holds at its end until the output
// register is free.
module median_ema_altitude_alarm_unit
    import mea_pkg::*;
#(
    parameter int WINDOW_LEN   = WINDOW_LEN_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic signed [SAMPLE_WIDTH-1:0] altitude_in,
    input  logic [TIME_W-1:0]              time_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] median_out,
    output logic signed [SAMPLE_WIDTH-1:0] smoothed_out,
    output logic [1:0]                     alarm_level,
    output logic                           alarm_on,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [((SAMPLE_WIDTH > ALPHA_W) ? SAMPLE_WIDTH : ALPHA_W)-1:0] cfg_data
);

    localparam int CFG_DATA_W = (SAMPLE_WIDTH > ALPHA_W) ? SAMPLE_WIDTH : ALPHA_W;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    mea_dp #(
        .WINDOW_LEN   (WINDOW_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CFG_DATA_W   (CFG_DATA_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req_type),
        .altitude_in  (altitude_in),
        .time_ms      (time_ms),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median_out   (median_out),
        .smoothed_out (smoothed_out),
        .alarm_level  (alarm_level),
        .alarm_on     (alarm_on)
    );

endmodule
